// ----- hw/rtl/first_fit_node_resource_picker_top_defines.svh -----
// Assertion macros for the first-fit node resource picker.
// Included by the top level; depends on nothing else.
`ifndef FIRST_FIT_NODE_RESOURCE_PICKER_TOP_DEFINES_SVH
`define FIRST_FIT_NODE_RESOURCE_PICKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FNRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FNRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fnrp_pkg.sv -----
// Shared widths, opcodes and types for the first-fit node resource picker.
// No dependencies.
package fnrp_pkg;

    localparam int CPU_W   = 16;
    localparam int MEM_W   = 32;
    localparam int DISK_W  = 32;
    localparam int ID_W    = 16;
    localparam int GMEM_W  = CPU_W + MEM_W;

    // Quotient bits the divider resolves; larger quotients set the overflow flag
    localparam int QUOT_W    = CPU_W;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NODE = 1'b1;

    typedef struct packed {
        logic              done;
        logic              over;
        logic [QUOT_W-1:0] quot;
    } div_stat_t;

endpackage

// ----- hw/rtl/fnrp_ifs.sv -----
// Request and response channel interfaces (valid/ready) for the picker.
// No dependencies.
interface fnrp_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] need_cpus;
    logic [31:0] mem_per_core;
    logic [31:0] need_disk;
    logic [15:0] node_id;
    logic [15:0] node_free_cpus;
    logic [31:0] node_free_mem;
    logic [31:0] node_free_disk;

    modport source (output valid, op, need_cpus, mem_per_core, need_disk, node_id,
                    node_free_cpus, node_free_mem, node_free_disk, input ready);
    modport sink (input valid, op, need_cpus, mem_per_core, need_disk, node_id,
                  node_free_cpus, node_free_mem, node_free_disk, output ready);
endinterface

interface fnrp_rsp_if;
    logic        valid;
    logic        ready;
    logic        take;
    logic [15:0] grant_node;
    logic [15:0] cpus_granted;
    logic [47:0] mem_granted;
    logic [31:0] disk_granted;
    logic        satisfied;

    modport source (output valid, take, grant_node, cpus_granted, mem_granted,
                    disk_granted, satisfied, input ready);
    modport sink (input valid, take, grant_node, cpus_granted, mem_granted,
                  disk_granted, satisfied, output ready);
endinterface

// ----- hw/rtl/fnrp_div.sv -----
// Bit-serial restoring divider: free memory / memory per core, quotient
// of QUOT_W bits, with larger quotients flagged as overflow. Depends on fnrp_pkg.
module fnrp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fnrp_pkg::MEM_W-1:0]    dividend,
    input  logic [fnrp_pkg::MEM_W-1:0]    divisor,
    output fnrp_pkg::div_stat_t           stat
);
    import fnrp_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_STEP} dstate_t;

    dstate_t             state_reg, state_next;
    logic [MEM_W-1:0]    rem_reg, rem_next;
    logic [MEM_W-1:0]    dvs_reg, dvs_next;
    logic [QUOT_W-1:0]   lo_reg, lo_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic                over_reg, over_next;

    logic [MEM_W:0]      sub_a;
    logic [MEM_W+1:0]    diff;
    logic                ge;

    // Shared subtractor: overflow check first, then one quotient bit a cycle
    always_comb
    begin
        if (state_reg == D_CHECK)
            sub_a = {1'b0, rem_reg};
        else
            sub_a = {rem_reg, lo_reg[QUOT_W-1]};
        diff = {1'b0, sub_a} - {2'b00, dvs_reg};
        ge   = ~diff[MEM_W+1];
    end

    // Sequence the divide
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        over_next  = over_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    rem_next   = {{QUOT_W{1'b0}}, dividend[MEM_W-1:QUOT_W]};
                    lo_next    = dividend[QUOT_W-1:0];
                    dvs_next   = divisor;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // High half not below divisor: quotient needs more than QUOT_W bits
                if (ge)
                begin
                    over_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    over_next  = 1'b0;
                    cnt_next   = STEP_W'(DIV_STEPS - 1);
                    state_next = D_STEP;
                end
            end
            D_STEP:
            begin
                rem_next = ge ? diff[MEM_W-1:0] : sub_a[MEM_W-1:0];
                lo_next  = {lo_reg[QUOT_W-2:0], ge};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            default:
                state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            lo_reg    <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            over_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            dvs_reg   <= dvs_next;
            lo_reg    <= lo_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            over_reg  <= over_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.over = over_reg;
    assign stat.quot = lo_reg;

endmodule

// ----- hw/rtl/first_fit_node_resource_picker_top.sv -----
// Top level of the first-fit node resource picker: sequencer, job state,
// product stage and output register. Depends on fnrp_pkg, fnrp_ifs, fnrp_div.
//
//  channel  dir  handshake     carries
//  req      in   valid/ready   job load (op 0) or node offer (op 1)
//  rsp      out  valid/ready   one grant per node offer
//
// A load request gives no response. A node offer with memory per core set
// runs the divider (overflow check, then 16 quotient steps unless the quotient
// overflows 16 bits), then product and output; with no memory per core it goes
// to product and output, and once the job is satisfied straight to output.
// req.ready is high only while the sequencer idles;
// a held response stalls the sequencer at its last step. Reset clears the job.
`include "first_fit_node_resource_picker_top_defines.svh"

module first_fit_node_resource_picker_top (
    input logic clk,
    input logic rst_n,
    fnrp_req_if.sink   req,
    fnrp_rsp_if.source rsp
);
    import fnrp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_OUT} state_t;

    state_t              state_reg, state_next;
    logic [CPU_W-1:0]    req_cpus_reg, req_cpus_next;
    logic [MEM_W-1:0]    req_mpc_reg, req_mpc_next;
    logic [DISK_W-1:0]   req_disk_reg, req_disk_next;
    logic [CPU_W-1:0]    cpus_sum_reg, cpus_sum_next;
    logic [DISK_W-1:0]   disk_sum_reg, disk_sum_next;
    logic                job_done_reg, job_done_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [CPU_W-1:0]    bound_reg, bound_next;
    logic [CPU_W-1:0]    cpus_reg, cpus_next;
    logic [DISK_W-1:0]   disk_reg, disk_next;
    logic [GMEM_W-1:0]   mem_reg, mem_next;
    logic                out_valid_reg, out_valid_next;
    logic                o_take_reg, o_take_next;
    logic [ID_W-1:0]     o_node_reg, o_node_next;
    logic [CPU_W-1:0]    o_cpus_reg, o_cpus_next;
    logic [GMEM_W-1:0]   o_mem_reg, o_mem_next;
    logic [DISK_W-1:0]   o_disk_reg, o_disk_next;
    logic                o_sat_reg, o_sat_next;

    logic                accept;
    logic                div_start;
    div_stat_t           div_stat;
    logic [CPU_W-1:0]    cpu_left;
    logic [DISK_W-1:0]   disk_left;
    logic [CPU_W-1:0]    cpu_bound;
    logic [DISK_W-1:0]   disk_take;
    logic [CPU_W-1:0]    cpus_total;
    logic [DISK_W-1:0]   disk_total;
    logic                take;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid & req.ready;
    assign div_start = accept & (req.op == OP_NODE) & ~job_done_reg & (req_mpc_reg != '0);

    fnrp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.node_free_mem),
        .divisor  (req_mpc_reg),
        .stat     (div_stat)
    );

    // Remaining need and the per-node bounds that do not involve memory
    always_comb
    begin
        cpu_left  = (cpus_sum_reg < req_cpus_reg) ? (req_cpus_reg - cpus_sum_reg) : '0;
        disk_left = (disk_sum_reg < req_disk_reg) ? (req_disk_reg - disk_sum_reg) : '0;
        cpu_bound = (req.node_free_cpus < cpu_left) ? req.node_free_cpus : cpu_left;
        disk_take = (req.node_free_disk < disk_left) ? req.node_free_disk : disk_left;
        cpus_total = cpus_sum_reg + cpus_reg;
        disk_total = disk_sum_reg + disk_reg;
        take       = (cpus_reg != '0) || (disk_reg != '0);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_cpus_next  = req_cpus_reg;
        req_mpc_next   = req_mpc_reg;
        req_disk_next  = req_disk_reg;
        cpus_sum_next  = cpus_sum_reg;
        disk_sum_next  = disk_sum_reg;
        job_done_next  = job_done_reg;
        id_next        = id_reg;
        bound_next     = bound_reg;
        cpus_next      = cpus_reg;
        disk_next      = disk_reg;
        mem_next       = mem_reg;
        o_take_next    = o_take_reg;
        o_node_next    = o_node_reg;
        o_cpus_next    = o_cpus_reg;
        o_mem_next     = o_mem_reg;
        o_disk_next    = o_disk_reg;
        o_sat_next     = o_sat_reg;
        // Drop the response once taken
        out_valid_next = out_valid_reg & ~rsp.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_LOAD)
                    begin
                        // Record the job and clear the running totals
                        req_cpus_next = req.need_cpus;
                        req_mpc_next  = req.mem_per_core;
                        req_disk_next = req.need_disk;
                        cpus_sum_next = '0;
                        disk_sum_next = '0;
                        job_done_next = (req.need_cpus == '0) && (req.need_disk == '0);
                    end
                    else if (job_done_reg)
                    begin
                        cpus_next  = '0;
                        disk_next  = '0;
                        mem_next   = '0;
                        id_next    = req.node_id;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        id_next    = req.node_id;
                        bound_next = cpu_bound;
                        cpus_next  = cpu_bound;
                        disk_next  = disk_take;
                        state_next = (req_mpc_reg == '0) ? S_MUL : S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // Memory limit applies only when the quotient fits
                if (div_stat.done)
                begin
                    if (!div_stat.over && (div_stat.quot < bound_reg))
                        cpus_next = div_stat.quot;
                    else
                        cpus_next = bound_reg;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // Charge memory and advance the totals
                mem_next      = GMEM_W'(cpus_reg) * GMEM_W'(req_mpc_reg);
                cpus_sum_next = cpus_total;
                disk_sum_next = disk_total;
                job_done_next = (cpus_total >= req_cpus_reg) && (disk_total >= req_disk_reg);
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    o_take_next    = take;
                    o_node_next    = take ? id_reg : '0;
                    o_cpus_next    = cpus_reg;
                    o_mem_next     = mem_reg;
                    o_disk_next    = disk_reg;
                    o_sat_next     = job_done_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_cpus_reg  <= '0;
            req_mpc_reg   <= '0;
            req_disk_reg  <= '0;
            cpus_sum_reg  <= '0;
            disk_sum_reg  <= '0;
            job_done_reg  <= 1'b0;
            id_reg        <= '0;
            bound_reg     <= '0;
            cpus_reg      <= '0;
            disk_reg      <= '0;
            mem_reg       <= '0;
            out_valid_reg <= 1'b0;
            o_take_reg    <= 1'b0;
            o_node_reg    <= '0;
            o_cpus_reg    <= '0;
            o_mem_reg     <= '0;
            o_disk_reg    <= '0;
            o_sat_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_cpus_reg  <= req_cpus_next;
            req_mpc_reg   <= req_mpc_next;
            req_disk_reg  <= req_disk_next;
            cpus_sum_reg  <= cpus_sum_next;
            disk_sum_reg  <= disk_sum_next;
            job_done_reg  <= job_done_next;
            id_reg        <= id_next;
            bound_reg     <= bound_next;
            cpus_reg      <= cpus_next;
            disk_reg      <= disk_next;
            mem_reg       <= mem_next;
            out_valid_reg <= out_valid_next;
            o_take_reg    <= o_take_next;
            o_node_reg    <= o_node_next;
            o_cpus_reg    <= o_cpus_next;
            o_mem_reg     <= o_mem_next;
            o_disk_reg    <= o_disk_next;
            o_sat_reg     <= o_sat_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.take         = o_take_reg;
    assign rsp.grant_node   = o_node_reg;
    assign rsp.cpus_granted = o_cpus_reg;
    assign rsp.mem_granted  = o_mem_reg;
    assign rsp.disk_granted = o_disk_reg;
    assign rsp.satisfied    = o_sat_reg;

    // Totals never pass the request
    `FNRP_ASSERT_NOW(a_totals_bounded, clk, rst_n, 1'b1, (cpus_sum_reg <= req_cpus_reg) && (disk_sum_reg <= req_disk_reg), "running totals exceed the request")
    // Done flag is only set once the totals cover the request
    `FNRP_ASSERT_NOW(a_done_consistent, clk, rst_n, job_done_reg, (cpus_sum_reg >= req_cpus_reg) && (disk_sum_reg >= req_disk_reg), "job done flag out of step with totals")
    // Divider finishes only while the sequencer waits on it
    `FNRP_ASSERT_NOW(a_div_owner, clk, rst_n, div_stat.done, state_reg == S_DIV, "divider result with no divide pending")
    // Take flag matches the granted amounts
    `FNRP_ASSERT_NOW(a_take_match, clk, rst_n, rsp.valid, rsp.take == ((rsp.cpus_granted != '0) || (rsp.disk_granted != '0)), "take flag does not match grants")

endmodule
